// ===== rtl/core/gnidx_pkg.sv =====
`default_nettype none
package gnidx_pkg;

	localparam int IDX_W = 24;
	localparam int RS_W = 16;
	localparam int PS_W = 24;
	localparam int SUM_W = IDX_W + 3;

	// modes
	localparam logic [2:0] MODE_N8 = 3'd0;
	localparam logic [2:0] MODE_N24 = 3'd1;
	localparam logic [2:0] MODE_KNIGHT = 3'd2;
	localparam logic [2:0] MODE_N6 = 3'd3;
	localparam logic [2:0] MODE_N18 = 3'd4;
	localparam logic [2:0] MODE_N26 = 3'd5;

	// result status codes
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_OUT = 2'd1;
	localparam logic [1:0] ST_BAD = 2'd2;

	// register indexes
	localparam logic [1:0] REG_ROW = 2'd0;
	localparam logic [1:0] REG_PLANE = 2'd1;
	localparam logic [1:0] REG_TOTAL = 2'd2;

	localparam logic signed [2:0] P1 = 3'sd1;
	localparam logic signed [2:0] P2 = 3'sd2;
	localparam logic signed [2:0] M1 = -3'sd1;
	localparam logic signed [2:0] M2 = -3'sd2;
	localparam logic signed [2:0] Z0 = 3'sd0;

	typedef struct packed {
		logic signed [2:0] dx;
		logic signed [2:0] dy;
		logic signed [2:0] dz;
		logic              def;
	} nb_t;

	// item traveling through the remainder pipeline
	typedef struct packed {
		logic [2:0]        mode;
		logic signed [2:0] dx;
		logic signed [2:0] dy;
		logic signed [2:0] dz;
		logic [1:0]        pre;
		logic [IDX_W-1:0]  idx;
		logic [IDX_W-1:0]  dvd;
		logic [RS_W-1:0]   rx;
		logic [PS_W-1:0]   rp;
	} item_t;

	// eight ring in order E NE N NW W SW S SE
	function automatic nb_t ring8(input logic [2:0] k, input logic signed [2:0] dz);
		nb_t r;
		r.dz = dz;
		r.def = 1'b1;
		case (k)
			3'd0: begin r.dx = P1; r.dy = Z0; end
			3'd1: begin r.dx = P1; r.dy = M1; end
			3'd2: begin r.dx = Z0; r.dy = M1; end
			3'd3: begin r.dx = M1; r.dy = M1; end
			3'd4: begin r.dx = M1; r.dy = Z0; end
			3'd5: begin r.dx = M1; r.dy = P1; end
			3'd6: begin r.dx = Z0; r.dy = P1; end
			default: begin r.dx = P1; r.dy = P1; end
		endcase
		return r;
	endfunction

	function automatic nb_t mk(input logic signed [2:0] dx, input logic signed [2:0] dy,
			input logic signed [2:0] dz);
		nb_t r;
		r.dx = dx;
		r.dy = dy;
		r.dz = dz;
		r.def = 1'b1;
		return r;
	endfunction

	// neighbor offsets per mode and direction
	function automatic nb_t nb_lookup(input logic [2:0] mode, input logic [4:0] dir);
		nb_t r;
		logic [4:0] k5;
		logic [4:0] k9;
		logic [4:0] k13;
		logic [4:0] k17;
		r = '0;
		k5 = dir - 5'd5;
		k9 = dir - 5'd9;
		k13 = dir - 5'd13;
		k17 = dir - 5'd17;
		case (mode)
			MODE_N8: begin
				if (dir < 5'd8) r = ring8(dir[2:0], Z0);
			end
			MODE_N24: begin
				case (dir)
					5'd8:  r = mk(P2, Z0, Z0);
					5'd9:  r = mk(P2, M1, Z0);
					5'd10: r = mk(P2, M2, Z0);
					5'd11: r = mk(P1, M2, Z0);
					5'd12: r = mk(Z0, M2, Z0);
					5'd13: r = mk(M1, M2, Z0);
					5'd14: r = mk(M2, M2, Z0);
					5'd15: r = mk(M2, M1, Z0);
					5'd16: r = mk(M2, Z0, Z0);
					5'd17: r = mk(M2, P1, Z0);
					5'd18: r = mk(M2, P2, Z0);
					5'd19: r = mk(M1, P2, Z0);
					5'd20: r = mk(Z0, P2, Z0);
					5'd21: r = mk(P1, P2, Z0);
					5'd22: r = mk(P2, P2, Z0);
					5'd23: r = mk(P2, P1, Z0);
					default: begin
						if (dir < 5'd8) r = ring8(dir[2:0], Z0);
					end
				endcase
			end
			MODE_KNIGHT: begin
				case (dir)
					5'd0: r = mk(P2, M1, Z0);
					5'd1: r = mk(P1, M2, Z0);
					5'd2: r = mk(M1, M2, Z0);
					5'd3: r = mk(M2, M1, Z0);
					5'd4: r = mk(M2, P1, Z0);
					5'd5: r = mk(M1, P2, Z0);
					5'd6: r = mk(P1, P2, Z0);
					5'd7: r = mk(P2, P1, Z0);
					default: r = '0;
				endcase
			end
			MODE_N6: begin
				case (dir)
					5'd0, 5'd2, 5'd4, 5'd6: r = ring8(dir[2:0], Z0);
					5'd10: r = mk(Z0, Z0, M1);
					5'd11: r = mk(Z0, Z0, P1);
					default: r = '0;
				endcase
			end
			MODE_N18: begin
				if (dir < 5'd4) r = ring8({dir[1:0], 1'b0}, P1);
				else if (dir == 5'd4) r = mk(Z0, Z0, P1);
				else if (dir < 5'd13) r = ring8(k5[2:0], Z0);
				else if (dir < 5'd17) r = ring8({k13[1:0], 1'b0}, M1);
				else if (dir == 5'd17) r = mk(Z0, Z0, M1);
			end
			MODE_N26: begin
				if (dir < 5'd8) r = ring8(dir[2:0], P1);
				else if (dir == 5'd8) r = mk(Z0, Z0, P1);
				else if (dir < 5'd17) r = ring8(k9[2:0], Z0);
				else if (dir < 5'd25) r = ring8(k17[2:0], M1);
				else if (dir == 5'd25) r = mk(Z0, Z0, M1);
			end
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/gnidx_rem_step.sv =====
`default_nettype none
module gnidx_rem_step import gnidx_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [RS_W-1:0]   row_size,
	input  wire logic [PS_W-1:0]   plane_size,
	input  wire logic              in_valid,
	output      logic              in_stall,
	input  wire item_t             in_item,
	output      logic              out_valid,
	input  wire logic              out_stall,
	output      item_t             out_item
);

	logic          v_q;
	item_t         item_q;
	logic          en;
	logic          b;
	logic [RS_W:0] tx;
	logic [PS_W:0] tp;
	item_t         nxt;

	// one restoring remainder step for both divisors
	always_comb begin
		b = in_item.dvd[IDX_W-1];
		tx = {in_item.rx, b};
		tp = {in_item.rp, b};
		if (tx >= {1'b0, row_size}) tx = tx - {1'b0, row_size};
		if (tp >= {1'b0, plane_size}) tp = tp - {1'b0, plane_size};
		nxt = in_item;
		nxt.dvd = {in_item.dvd[IDX_W-2:0], 1'b0};
		nxt.rx = tx[RS_W-1:0];
		nxt.rp = tp[PS_W-1:0];
	end

	assign en = !v_q || !out_stall;
	assign in_stall = !en;

	// stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			item_q <= nxt;
		end
	end

	assign out_valid = v_q;
	assign out_item = item_q;

endmodule
`default_nettype wire

// ===== rtl/core/grid_neighbor_index_top.sv =====
// neighbor address generator for linear-indexed 2D and 3D grids
// pipeline: decode, 24 remainder steps, 2 check stages
// throughput: one beat per cycle while stall_out is low; set by the one-bit-per-stage remainder pipeline
// stalled stages hold while empty stages upstream keep filling
// reset clears all valid bits and loads row 256, plane 65536, total 65536
`default_nettype none
module grid_neighbor_index_top import gnidx_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             psel,
	input  wire logic             penable,
	input  wire logic             pwrite,
	input  wire logic [3:0]       paddr,
	input  wire logic [31:0]      pwdata,
	output      logic [31:0]      prdata,
	output      logic             pready,
	input  wire logic             valid_in,
	output      logic             stall_in,
	input  wire logic [2:0]       opcode,
	input  wire logic [4:0]       direction,
	input  wire logic [IDX_W-1:0] point_index,
	output      logic             valid_out,
	input  wire logic             stall_out,
	output      logic [IDX_W-1:0] neighbor_index,
	output      logic [1:0]       status
);

	logic [RS_W-1:0]  row_q;
	logic [PS_W-1:0]  plane_q;
	logic [IDX_W-1:0] total_q;

	// config registers
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= RS_W'(256);
			plane_q <= PS_W'(65536);
			total_q <= IDX_W'(65536);
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_ROW:   row_q <= pwdata[RS_W-1:0];
				REG_PLANE: plane_q <= pwdata[PS_W-1:0];
				REG_TOTAL: total_q <= pwdata[IDX_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_ROW:   prdata = 32'(row_q);
			REG_PLANE: prdata = 32'(plane_q);
			REG_TOTAL: prdata = 32'(total_q);
			default:   prdata = '0;
		endcase
	end

	// stage 1: decode direction and early status
	logic  v_s1;
	item_t item_s1;
	logic  en_s1;
	nb_t   nb;
	item_t dec;
	logic  stall_chain [IDX_W+1];
	logic  valid_chain [IDX_W+1];
	item_t item_chain [IDX_W+1];

	always_comb begin
		nb = nb_lookup(opcode, direction);
		dec.mode = opcode;
		dec.dx = nb.dx;
		dec.dy = nb.dy;
		dec.dz = nb.dz;
		dec.idx = point_index;
		dec.dvd = point_index;
		dec.rx = '0;
		dec.rp = '0;
		if (!nb.def) dec.pre = ST_BAD;
		else if (row_q == '0) dec.pre = ST_OUT;
		else if (opcode >= MODE_N6 && plane_q == '0) dec.pre = ST_OUT;
		else if (point_index >= total_q) dec.pre = ST_OUT;
		else dec.pre = ST_OK;
	end

	assign en_s1 = !v_s1 || !stall_chain[0];
	assign stall_in = !en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && valid_in) begin
			item_s1 <= dec;
		end
	end

	// remainder pipeline: column and offset within the plane
	assign valid_chain[0] = v_s1;
	assign item_chain[0] = item_s1;

	for (genvar g = 0; g < IDX_W; g++) begin : g_step
		gnidx_rem_step u_step (
			.clk        (clk),
			.arst_n     (arst_n),
			.row_size   (row_q),
			.plane_size (plane_q),
			.in_valid   (valid_chain[g]),
			.in_stall   (stall_chain[g]),
			.in_item    (item_chain[g]),
			.out_valid  (valid_chain[g+1]),
			.out_stall  (stall_chain[g+1]),
			.out_item   (item_chain[g+1])
		);
	end

	// stage 26: bound checks and neighbor sum
	logic                    v_s26;
	logic                    en_s26;
	logic [1:0]              pre_s26;
	logic                    ok_s26;
	logic signed [SUM_W-1:0] r_s26;
	logic                    v_s27;
	logic                    en_s27;
	logic [IDX_W-1:0]        nbr_s27;
	logic [1:0]              st_s27;
	item_t                   it;
	logic signed [SUM_W-1:0] i_s, n_s, rs_s, ps_s, x_s, yp_s, dx_s, dyrs_s, r_c;
	logic                    ok_c;
	logic                    is3d;

	always_comb begin
		it = item_chain[IDX_W];
		is3d = it.mode >= MODE_N6;
		i_s = $signed({3'b0, it.idx});
		n_s = $signed({3'b0, total_q});
		rs_s = $signed(SUM_W'(row_q));
		ps_s = $signed(SUM_W'(plane_q));
		x_s = $signed(SUM_W'(it.rx));
		yp_s = $signed(SUM_W'(it.rp));
		dx_s = SUM_W'(it.dx);
		dyrs_s = (it.dy == P2 || it.dy == M2) ? (rs_s <<< 1) : rs_s;
		ok_c = 1'b1;
		if (it.dx > Z0 && !(x_s < rs_s - dx_s)) ok_c = 1'b0;
		if (it.dx < Z0 && !(x_s >= -dx_s)) ok_c = 1'b0;
		if (!is3d) begin
			if (it.dy < Z0 && !(i_s >= dyrs_s)) ok_c = 1'b0;
			if (it.dy > Z0 && !(i_s < n_s - dyrs_s)) ok_c = 1'b0;
		end else begin
			if (it.dy < Z0 && !(yp_s >= rs_s)) ok_c = 1'b0;
			if (it.dy > Z0 && !(yp_s < ps_s - rs_s)) ok_c = 1'b0;
			if (it.dz < Z0 && !(i_s >= ps_s)) ok_c = 1'b0;
			if (it.dz > Z0 && !(i_s < n_s - ps_s)) ok_c = 1'b0;
		end
		r_c = i_s + dx_s;
		if (it.dy < Z0) r_c = r_c - dyrs_s;
		else if (it.dy > Z0) r_c = r_c + dyrs_s;
		if (is3d) begin
			if (it.dz < Z0) r_c = r_c - ps_s;
			else if (it.dz > Z0) r_c = r_c + ps_s;
		end
	end

	assign en_s26 = !v_s26 || !stall_out || !v_s27;
	assign stall_chain[IDX_W] = !en_s26;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s26 <= 1'b0;
		end else if (en_s26) begin
			v_s26 <= valid_chain[IDX_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s26 && valid_chain[IDX_W]) begin
			pre_s26 <= it.pre;
			ok_s26 <= ok_c;
			r_s26 <= r_c;
		end
	end

	// stage 27: final range check, output register
	logic [1:0] st_c;

	always_comb begin
		if (pre_s26 != ST_OK) st_c = pre_s26;
		else if (!ok_s26) st_c = ST_OUT;
		else if (r_s26 < 0 || r_s26 >= $signed({3'b0, total_q})) st_c = ST_OUT;
		else st_c = ST_OK;
	end

	assign en_s27 = !v_s27 || !stall_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s27 <= 1'b0;
		end else if (en_s27) begin
			v_s27 <= v_s26;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s27 && v_s26) begin
			st_s27 <= st_c;
			nbr_s27 <= (st_c == ST_OK) ? r_s26[IDX_W-1:0] : '0;
		end
	end

	assign valid_out = v_s27;
	assign neighbor_index = nbr_s27;
	assign status = st_s27;

endmodule
`default_nettype wire

// ===== dv/grid_neighbor_index_top_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module grid_neighbor_index_top_tb;
	import gnidx_pkg::*;

	localparam logic [3:0] ADDR_ROW = 4'd0;
	localparam logic [3:0] ADDR_PLANE = 4'd4;
	localparam logic [3:0] ADDR_TOTAL = 4'd8;
	localparam int LATENCY = 27;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		logic [IDX_W-1:0] nbr;
		logic [1:0]       st;
	} addr_result_t;

	typedef struct {
		logic [2:0]       op;
		logic [4:0]       dir;
		logic [IDX_W-1:0] pt;
		bit               fixed;
		logic [IDX_W-1:0] nbr;
		logic [1:0]       st;
	} table_row_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [3:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	logic valid_in, stall_in;
	logic [2:0] opcode;
	logic [4:0] direction;
	logic [IDX_W-1:0] point_index;
	logic valid_out, stall_out;
	logic [IDX_W-1:0] neighbor_index;
	logic [1:0] status;

	// active grid geometry
	logic [15:0] cur_row;
	logic [23:0] cur_plane;
	logic [23:0] cur_total;

	addr_result_t pending_addrs[$];
	int errors;
	int cycles;
	int send_idle_pct;
	int recv_idle_pct;

	grid_neighbor_index_top u_top (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.valid_in(valid_in), .stall_in(stall_in),
		.opcode(opcode), .direction(direction), .point_index(point_index),
		.valid_out(valid_out), .stall_out(stall_out),
		.neighbor_index(neighbor_index), .status(status)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// neighbor offset for a mode and direction; returns 0 when undefined
	function automatic bit offset_of(input logic [2:0] op, input logic [4:0] dir,
			output int dx, output int dy, output int dz);
		int rx[8];
		int ry[8];
		int k;
		rx = '{1, 1, 0, -1, -1, -1, 0, 1};
		ry = '{0, -1, -1, -1, 0, 1, 1, 1};
		dx = 0;
		dy = 0;
		dz = 0;
		k = dir;
		case (op)
			MODE_N8: begin
				if (k >= 8) return 0;
				dx = rx[k];
				dy = ry[k];
			end
			MODE_N24: begin
				if (k < 8) begin
					dx = rx[k];
					dy = ry[k];
				end else if (k < 24) begin
					// distance-two ring from east, toward lower rows first
					case (k)
						8: begin dx = 2; dy = 0; end
						9: begin dx = 2; dy = -1; end
						10: begin dx = 2; dy = -2; end
						11: begin dx = 1; dy = -2; end
						12: begin dx = 0; dy = -2; end
						13: begin dx = -1; dy = -2; end
						14: begin dx = -2; dy = -2; end
						15: begin dx = -2; dy = -1; end
						16: begin dx = -2; dy = 0; end
						17: begin dx = -2; dy = 1; end
						18: begin dx = -2; dy = 2; end
						19: begin dx = -1; dy = 2; end
						20: begin dx = 0; dy = 2; end
						21: begin dx = 1; dy = 2; end
						22: begin dx = 2; dy = 2; end
						default: begin dx = 2; dy = 1; end
					endcase
				end else return 0;
			end
			MODE_KNIGHT: begin
				case (k)
					0: begin dx = 2; dy = -1; end
					1: begin dx = 1; dy = -2; end
					2: begin dx = -1; dy = -2; end
					3: begin dx = -2; dy = -1; end
					4: begin dx = -2; dy = 1; end
					5: begin dx = -1; dy = 2; end
					6: begin dx = 1; dy = 2; end
					7: begin dx = 2; dy = 1; end
					default: return 0;
				endcase
			end
			MODE_N6: begin
				if (k == 0 || k == 2 || k == 4 || k == 6) begin
					dx = rx[k];
					dy = ry[k];
				end else if (k == 10) dz = -1;
				else if (k == 11) dz = 1;
				else return 0;
			end
			MODE_N18: begin
				if (k < 4) begin
					dx = rx[2 * k];
					dy = ry[2 * k];
					dz = 1;
				end else if (k == 4) dz = 1;
				else if (k < 13) begin
					dx = rx[k - 5];
					dy = ry[k - 5];
				end else if (k < 17) begin
					dx = rx[2 * (k - 13)];
					dy = ry[2 * (k - 13)];
					dz = -1;
				end else if (k == 17) dz = -1;
				else return 0;
			end
			MODE_N26: begin
				if (k < 8) begin
					dx = rx[k];
					dy = ry[k];
					dz = 1;
				end else if (k == 8) dz = 1;
				else if (k < 17) begin
					dx = rx[k - 9];
					dy = ry[k - 9];
				end else if (k < 25) begin
					dx = rx[k - 17];
					dy = ry[k - 17];
					dz = -1;
				end else if (k == 25) dz = -1;
				else return 0;
			end
			default: return 0;
		endcase
		return 1;
	endfunction

	// neighbor address with border and image-size checks
	function automatic addr_result_t neighbor_addr(input logic [2:0] op,
			input logic [4:0] dir, input logic [IDX_W-1:0] pt);
		addr_result_t res;
		int dx, dy, dz;
		longint i, rs, ps, n, x, yp, r;
		bit ok;
		res.nbr = '0;
		res.st = ST_OUT;
		if (!offset_of(op, dir, dx, dy, dz)) begin
			res.st = ST_BAD;
			return res;
		end
		i = pt;
		rs = cur_row;
		ps = cur_plane;
		n = cur_total;
		if (rs == 0) return res;
		if (op >= MODE_N6 && ps == 0) return res;
		if (i >= n) return res;
		ok = 1;
		x = i % rs;
		if (dx > 0 && !(x < rs - dx)) ok = 0;
		if (dx < 0 && !(x >= -dx)) ok = 0;
		if (op < MODE_N6) begin
			if (dy < 0 && !(i >= -dy * rs)) ok = 0;
			if (dy > 0 && !(i < n - dy * rs)) ok = 0;
		end else begin
			yp = i % ps;
			if (dy < 0 && !(yp >= rs)) ok = 0;
			if (dy > 0 && !(yp < ps - rs)) ok = 0;
			if (dz < 0 && !(i >= ps)) ok = 0;
			if (dz > 0 && !(i < n - ps)) ok = 0;
		end
		if (!ok) return res;
		r = i + dx + dy * rs;
		if (op >= MODE_N6) r += dz * ps;
		if (r < 0 || r >= n) return res;
		res.nbr = r[IDX_W-1:0];
		res.st = ST_OK;
		return res;
	endfunction

	task automatic reg_write(input logic [3:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (addr)
			ADDR_ROW: cur_row = data[15:0];
			ADDR_PLANE: cur_plane = data[23:0];
			default: cur_total = data[23:0];
		endcase
		@(posedge clk);
	endtask

	task automatic set_geometry(input logic [15:0] rs, input logic [23:0] ps,
			input logic [23:0] n);
		// drain everything in flight first
		while (pending_addrs.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
		reg_write(ADDR_ROW, {16'd0, rs});
		reg_write(ADDR_PLANE, {8'd0, ps});
		reg_write(ADDR_TOTAL, {8'd0, n});
	endtask

	// one input beat; expectation is queued on acceptance
	task automatic send_beat(input logic [2:0] op, input logic [4:0] dir,
			input logic [IDX_W-1:0] pt, input bit fixed, input addr_result_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			valid_in <= 1'b0;
			@(posedge clk);
		end
		valid_in <= 1'b1;
		opcode <= op;
		direction <= dir;
		point_index <= pt;
		@(posedge clk);
		while (stall_in) @(posedge clk);
		pending_addrs.push_back(fixed ? want : neighbor_addr(op, dir, pt));
	endtask

	task automatic send_idle();
		valid_in <= 1'b0;
		@(posedge clk);
	endtask

	// mostly small images so borders are hit often
	task automatic random_beats(input int count, input bit is3d);
		addr_result_t none;
		logic [2:0] op;
		logic [4:0] dir;
		logic [IDX_W-1:0] pt;
		none.nbr = '0;
		none.st = ST_OK;
		for (int k = 0; k < count; k++) begin
			op = is3d ? 3'($urandom_range(3, 5)) : 3'($urandom_range(0, 2));
			if ($urandom_range(19) == 0) op = 3'($urandom_range(0, 7));
			dir = 5'($urandom_range(0, 25));
			if ($urandom_range(19) == 0) dir = 5'($urandom);
			if ($urandom_range(9) == 0) pt = IDX_W'($urandom);
			else pt = IDX_W'($urandom_range(0, cur_total + 2));
			send_beat(op, dir, pt, 1'b0, none);
		end
		send_idle();
	endtask

	// result side: random stall and compare
	always @(posedge clk) begin
		addr_result_t want;
		if (arst_n) begin
			if (valid_out && !stall_out) begin
				if (pending_addrs.size() == 0) begin
					$error("unexpected result beat neighbor_index=%0d status=%0d",
						neighbor_index, status);
					errors++;
				end else begin
					want = pending_addrs.pop_front();
					if (neighbor_index !== want.nbr) begin
						$error("neighbor_index expected %0d actual %0d", want.nbr,
							neighbor_index);
						errors++;
					end
					if (status !== want.st) begin
						$error("status expected %0d actual %0d", want.st, status);
						errors++;
					end
				end
			end
			stall_out <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		table_row_t dir_table[$];
		addr_result_t want;
		errors = 0;
		cycles = 0;
		send_idle_pct = 26;
		recv_idle_pct = 71;
		cur_row = 16'd256;
		cur_plane = 24'd65536;
		cur_total = 24'd65536;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		valid_in = 1'b0;
		opcode = '0;
		direction = '0;
		point_index = '0;
		stall_out = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows at reset geometry (256 x 256, one plane)
		dir_table = '{
			'{MODE_N8, 5'd0, 24'd0, 1'b1, 24'd1, ST_OK},
			'{MODE_N8, 5'd2, 24'd0, 1'b1, 24'd0, ST_OUT},
			'{MODE_N8, 5'd4, 24'd0, 1'b1, 24'd0, ST_OUT},
			'{MODE_N8, 5'd6, 24'd0, 1'b1, 24'd256, ST_OK},
			'{MODE_N8, 5'd8, 24'd5, 1'b1, 24'd0, ST_BAD},
			'{MODE_N8, 5'd31, 24'hFFFFFF, 1'b1, 24'd0, ST_BAD},
			'{MODE_N8, 5'd0, 24'hFFFFFF, 1'b1, 24'd0, ST_OUT},
			'{MODE_N8, 5'd7, 24'd65535, 1'b1, 24'd0, ST_OUT},
			'{MODE_N8, 5'd3, 24'd65535, 1'b1, 24'd65278, ST_OK},
			'{MODE_N24, 5'd14, 24'd1000, 1'b0, 24'd0, ST_OK},
			'{MODE_N24, 5'd22, 24'd1000, 1'b0, 24'd0, ST_OK},
			'{MODE_N24, 5'd24, 24'd1000, 1'b1, 24'd0, ST_BAD},
			'{MODE_KNIGHT, 5'd0, 24'd600, 1'b0, 24'd0, ST_OK},
			'{MODE_KNIGHT, 5'd5, 24'd254, 1'b0, 24'd0, ST_OK},
			'{MODE_KNIGHT, 5'd8, 24'd600, 1'b1, 24'd0, ST_BAD},
			'{MODE_N6, 5'd1, 24'd600, 1'b1, 24'd0, ST_BAD},
			'{MODE_N6, 5'd10, 24'd600, 1'b1, 24'd0, ST_OUT},
			'{MODE_N6, 5'd11, 24'd600, 1'b1, 24'd0, ST_OUT},
			'{MODE_N18, 5'd7, 24'd600, 1'b0, 24'd0, ST_OK},
			'{MODE_N18, 5'd18, 24'd600, 1'b1, 24'd0, ST_BAD},
			'{MODE_N26, 5'd12, 24'd600, 1'b0, 24'd0, ST_OK},
			'{MODE_N26, 5'd26, 24'd600, 1'b1, 24'd0, ST_BAD},
			'{3'd6, 5'd0, 24'd600, 1'b1, 24'd0, ST_BAD},
			'{3'd7, 5'd0, 24'd600, 1'b1, 24'd0, ST_BAD}
		};
		foreach (dir_table[k]) begin
			want.nbr = dir_table[k].nbr;
			want.st = dir_table[k].st;
			send_beat(dir_table[k].op, dir_table[k].dir, dir_table[k].pt,
				dir_table[k].fixed, want);
		end
		send_idle();

		// 3D cube 4x4x4, all 26 directions from interior point 21
		set_geometry(16'd4, 24'd16, 24'd64);
		for (int m = 0; m < 26; m++) begin
			want.nbr = '0;
			want.st = ST_OK;
			send_beat(MODE_N26, 5'(m), 24'd21, 1'b0, want);
		end
		send_idle();
		random_beats(250, 1'b1);

		// 2D small image
		send_idle_pct = 71;
		recv_idle_pct = 26;
		set_geometry(16'd5, 24'd35, 24'd35);
		random_beats(250, 1'b0);
		// single-point and zero sizes
		set_geometry(16'd1, 24'd1, 24'd1);
		random_beats(60, 1'b1);
		set_geometry(16'd0, 24'd0, 24'd40);
		random_beats(60, 1'b0);
		random_beats(40, 1'b1);
		// inconsistent sizes
		set_geometry(16'd7, 24'd20, 24'd90);
		random_beats(200, 1'b1);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		// largest sizes
		set_geometry(16'hFFFF, 24'hFFFFFF, 24'hFFFFFF);
		random_beats(150, 1'b0);
		random_beats(150, 1'b1);
		set_geometry(16'd3, 24'd12, 24'd60);
		random_beats(300, 1'b1);
		set_geometry(16'd16, 24'd256, 24'd256);
		random_beats(250, 1'b0);

		while (pending_addrs.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
		if (errors == 0 && pending_addrs.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
`default_nettype wire

// ===== grid_neighbor_index_top.f =====
rtl/core/gnidx_pkg.sv
rtl/core/gnidx_rem_step.sv
rtl/core/grid_neighbor_index_top.sv
dv/grid_neighbor_index_top_tb.sv
